// ===== rtl/tpmbl_pkg.sv =====
package tpmbl_pkg;

  localparam int NODE_W   = 10;
  localparam int PORT_WW  = 32;
  localparam int STEPS_W  = 10;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_PATH    = 2'd1;
  localparam logic [1:0] REQ_ANC     = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic ANS_PATH = 1'b0;
  localparam logic ANS_ANC  = 1'b1;

endpackage

// ===== rtl/tpmbl_ram.sv =====
module tpmbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/tree_path_max_binary_lifting.sv =====
// Tree path maximum and k-th ancestor by binary lifting.
// Input channel (in_valid_i / in_stall_o) carries load words and query words.
// A load word for an in-range node writes level 0 of the lifting table and
// the depth store; a load word marked last_entry then starts a table build,
// during which no word is taken. A path query first equalises depths, then
// finishes if the nodes already meet, else runs a joint climb and a final
// step to the meeting node; an ancestor query climbs through the set bits of
// its step count. The table memory has a single read port, one entry read
// per cycle.
// One item is worked at a time; the next is taken once the sequencer is idle,
// even while the previous result still waits in the output register.
// Output channel (out_valid_o / out_stall_i): one result word per valid
// query; a stalled result holds, and a finished query waits for the output
// register to free up. Out-of-range queries and unknown requests give none.
// Reset clears the sequencer and the output valid; table contents are
// undefined until loaded and built.
module tree_path_max_binary_lifting #(
  parameter int NODES       = 1024,
  parameter int LEVELS      = 10,
  parameter int WEIGHT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  node_i,
  input  logic [9:0]  partner_node_i,
  input  logic [31:0] edge_weight_i,
  input  logic [9:0]  node_depth_i,
  input  logic [9:0]  steps_i,
  input  logic        last_entry_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] path_max_o,
  output logic [9:0]  meeting_node_o,
  output logic [9:0]  ancestor_node_o,
  output logic        answer_kind_o
);

  localparam int NW = tpmbl_pkg::NODE_W;
  localparam int WB = WEIGHT_BITS;
  localparam int TW = NW + WB;
  localparam int AW = $clog2(LEVELS * NODES);
  localparam int IW = $clog2(NODES);
  localparam int LW = $clog2(LEVELS) + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_BRD1, S_BRD2, S_BWR, S_PD1, S_PD2, S_UP, S_UPW, S_CHK,
    S_L1, S_L2, S_L3, S_F1, S_F2, S_F3, S_KUP, S_KW, S_DONE
  } state_e;

  state_e state_q;
  logic [AW-1:0] base_q;
  logic [IW-1:0] i_q;
  logic [LW-1:0] lv_q;
  logic [NW-1:0] a_q, b_q, ua_q, meet_q;
  logic [WB-1:0] acc_q, wa_q;
  logic [NW-1:0] da_q, diff_q, k_q;
  logic          kind_q;

  logic          out_valid_q, out_kind_q;
  logic [31:0]   out_max_q;
  logic [NW-1:0] out_meet_q, out_anc_q;

  logic          tab_we;
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [TW-1:0] tab_wdata, tab_rdata;
  logic          dep_we;
  logic [IW-1:0] dep_raddr;
  logic [NW-1:0] dep_rdata;

  logic [NW-1:0] r_anc;
  logic [WB-1:0] r_w, mx1, mx2, mxu;
  logic          accept, n_ok, p_ok, up_bit, k_bit, out_free;

  assign r_anc = tab_rdata[TW-1 -: NW];
  assign r_w   = tab_rdata[WB-1:0];
  assign mx1   = (acc_q > wa_q) ? acc_q : wa_q;
  assign mx2   = (mx1 > r_w) ? mx1 : r_w;
  assign mxu   = (acc_q > r_w) ? acc_q : r_w;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign n_ok       = (32'(node_i) < NODES);
  assign p_ok       = (32'(partner_node_i) < NODES);
  assign up_bit     = (32'(lv_q) < 10) ? diff_q[4'(lv_q)] : 1'b0;
  assign k_bit      = (32'(lv_q) < 10) ? k_q[4'(lv_q)] : 1'b0;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = AW'(node_i);
    tab_wdata = {(p_ok ? partner_node_i : node_i), WB'(edge_weight_i)};
    dep_we    = 1'b0;
    dep_raddr = IW'(node_i);
    tab_raddr = AW'(base_q + AW'(a_q));
    if (state_q == S_IDLE && accept && req_type_i == tpmbl_pkg::REQ_LOAD && n_ok) begin
      tab_we = 1'b1;
      dep_we = 1'b1;
    end
    if (state_q == S_BWR) begin
      tab_we    = 1'b1;
      tab_waddr = AW'(base_q + AW'(NODES) + AW'(i_q));
      tab_wdata = {r_anc, (wa_q > r_w) ? wa_q : r_w};
    end
    if (state_q == S_PD1) begin
      dep_raddr = IW'(b_q);
    end
    unique case (state_q)
      S_BRD1:  tab_raddr = AW'(base_q + AW'(i_q));
      S_BRD2:  tab_raddr = AW'(base_q + AW'(r_anc));
      S_L2:    tab_raddr = AW'(base_q + AW'(b_q));
      S_F1:    tab_raddr = AW'(a_q);
      S_F2:    tab_raddr = AW'(b_q);
      default: tab_raddr = AW'(base_q + AW'(a_q));
    endcase
  end

  tpmbl_ram #(.WIDTH(TW), .DEPTH(LEVELS * NODES)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  tpmbl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_dep (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (IW'(node_i)),
    .wdata_i (node_depth_i),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            a_q    <= node_i;
            b_q    <= partner_node_i;
            k_q    <= steps_i;
            acc_q  <= '0;
            base_q <= '0;
            i_q    <= '0;
            priority case (req_type_i)
              tpmbl_pkg::REQ_LOAD: begin
                if (last_entry_i && LEVELS > 1) begin
                  lv_q    <= LW'(1);
                  state_q <= S_BRD1;
                end
              end
              tpmbl_pkg::REQ_PATH: begin
                kind_q <= tpmbl_pkg::ANS_PATH;
                if (n_ok && p_ok) begin
                  state_q <= S_PD1;
                end
              end
              tpmbl_pkg::REQ_ANC: begin
                kind_q <= tpmbl_pkg::ANS_ANC;
                lv_q   <= '0;
                if (n_ok) begin
                  state_q <= S_KUP;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_BRD1: state_q <= S_BRD2;
        S_BRD2: begin
          wa_q    <= r_w;
          state_q <= S_BWR;
        end
        S_BWR: begin
          state_q <= S_BRD1;
          if (i_q == IW'(NODES - 1)) begin
            i_q    <= '0;
            base_q <= AW'(base_q + AW'(NODES));
            lv_q   <= lv_q + LW'(1);
            if (lv_q == LW'(LEVELS - 1)) begin
              state_q <= S_IDLE;
            end
          end else begin
            i_q <= i_q + IW'(1);
          end
        end
        S_PD1: begin
          da_q    <= dep_rdata;
          state_q <= S_PD2;
        end
        S_PD2: begin
          lv_q <= '0;
          if (da_q < dep_rdata) begin
            a_q    <= b_q;
            b_q    <= a_q;
            diff_q <= dep_rdata - da_q;
          end else begin
            diff_q <= da_q - dep_rdata;
          end
          state_q <= S_UP;
        end
        S_UP, S_UPW: begin
          if (state_q == S_UP && up_bit) begin
            state_q <= S_UPW;
          end else begin
            if (state_q == S_UPW) begin
              acc_q <= mxu;
              a_q   <= r_anc;
            end
            if (lv_q == LW'(LEVELS - 1)) begin
              state_q <= S_CHK;
            end else begin
              lv_q    <= lv_q + LW'(1);
              base_q  <= AW'(base_q + AW'(NODES));
              state_q <= S_UP;
            end
          end
        end
        S_CHK: begin
          if (a_q == b_q) begin
            meet_q  <= a_q;
            state_q <= S_DONE;
          end else begin
            lv_q    <= LW'(LEVELS - 1);
            base_q  <= AW'((LEVELS - 1) * NODES);
            state_q <= S_L1;
          end
        end
        S_L1: state_q <= S_L2;
        S_L2: begin
          ua_q    <= r_anc;
          wa_q    <= r_w;
          state_q <= S_L3;
        end
        S_L3: begin
          if (ua_q != r_anc) begin
            acc_q <= mx2;
            a_q   <= ua_q;
            b_q   <= r_anc;
          end
          if (lv_q == '0) begin
            state_q <= S_F1;
          end else begin
            lv_q    <= lv_q - LW'(1);
            base_q  <= AW'(base_q - AW'(NODES));
            state_q <= S_L1;
          end
        end
        S_F1: state_q <= S_F2;
        S_F2: begin
          wa_q    <= r_w;
          meet_q  <= r_anc;
          state_q <= S_F3;
        end
        S_F3: begin
          acc_q   <= mx2;
          state_q <= S_DONE;
        end
        S_KUP, S_KW: begin
          if (state_q == S_KUP && k_bit) begin
            state_q <= S_KW;
          end else begin
            if (state_q == S_KW) begin
              a_q <= r_anc;
            end
            if (lv_q == LW'(LEVELS - 1)) begin
              state_q <= S_DONE;
            end else begin
              lv_q    <= lv_q + LW'(1);
              base_q  <= AW'(base_q + AW'(NODES));
              state_q <= S_KUP;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= kind_q;
            if (kind_q == tpmbl_pkg::ANS_ANC) begin
              out_max_q  <= '0;
              out_meet_q <= '0;
              out_anc_q  <= a_q;
            end else begin
              out_max_q  <= 32'(acc_q);
              out_meet_q <= meet_q;
              out_anc_q  <= '0;
            end
            state_q <= S_IDLE;
          end else if (!out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign path_max_o      = out_max_q;
  assign meeting_node_o  = out_meet_q;
  assign ancestor_node_o = out_anc_q;
  assign answer_kind_o   = out_kind_q;

  a_path_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && answer_kind_o == tpmbl_pkg::ANS_PATH |-> ancestor_node_o == '0)
    else $error("path answer carries an ancestor");

  a_anc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && answer_kind_o == tpmbl_pkg::ANS_ANC |->
      path_max_o == '0 && meeting_node_o == '0)
    else $error("ancestor answer carries path fields");

  a_path_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == tpmbl_pkg::REQ_PATH && n_ok && p_ok |=> state_q == S_PD1)
    else $error("path query did not start");

  a_done_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && out_valid_q == 1'b0 ##1 out_valid_o |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion");

endmodule
